// File: rtl/core/bfmac_pkg.sv
// Shared constants and types of the bit-flip MAC accumulator.
`default_nettype none
package bfmac_pkg;

    localparam int MAX_BYTES   = 64;
    localparam int TAG_BITS    = 64;
    localparam int TAG_W       = 64;
    localparam int IDX_W       = 10;
    localparam int TABLE_DEPTH = 8 * MAX_BYTES + 1;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);

    localparam logic [IDX_W:0]   DEPTH_LIMIT = (IDX_W + 1)'(TABLE_DEPTH);
    localparam logic [ADDR_W-1:0] MSG_BITS   = ADDR_W'(8 * MAX_BYTES);
    localparam logic [TAG_W-1:0] TAG_MASK    = {TAG_W{1'b1}} >> (TAG_W - TAG_BITS);

    localparam logic [1:0] ACT_LOAD   = 2'd0;
    localparam logic [1:0] ACT_BYTE   = 2'd1;
    localparam logic [1:0] ACT_FINISH = 2'd2;

    localparam logic [2:0] BIT_LAST  = 3'd7;
    localparam logic [ADDR_W-1:0] BYTE_STEP = ADDR_W'(8);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_BYTE = 3'b010,
        S_FIN  = 3'b100
    } t_state;

endpackage
`default_nettype wire

// File: rtl/core/bfmac_ram.sv
// Generic single-port synchronous RAM with registered read data.
`default_nettype none
module bfmac_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 513,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_addr,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule
`default_nettype wire

// File: rtl/core/bit_flip_mac_accumulator.sv
// Top level of the bit-flip MAC accumulator: sequencer, running tag and flip table.
//
// Usage: present a word with start high while busy is low; it is taken at that
// clock edge. A load word (action 0) writes entry_index of the flip table in
// the accept cycle and leaves busy low, so loads can stream one per cycle;
// indexes past the table end are dropped. A message byte (action 1) keeps busy
// high after the accept cycle while the single-port table RAM delivers one flip
// word per cycle, one per bit, most significant bit first, and the word is
// XORed into the tag when its bit is set. Bytes past the table capacity are
// dropped and flag overflow, leaving busy low. A finish word (action 2) reads
// the padding entry at the next bit position and keeps busy high while it comes
// in; in the cycle after that, o_done is high for a single cycle and the result
// word (o_tag, o_tag_match, o_overflow) shows, held until the next result; the
// receiver cannot stall it. The accumulator then restarts from the seed. Action
// code 3 is dropped. The seed register is written through i_cfg_we/i_cfg_wdata
// while idle; it reloads the running tag only if no byte of the current message
// has been taken yet. Table entries read before they were ever loaded return
// undefined data. No clearing pass runs after reset.
`default_nettype none
module bit_flip_mac_accumulator (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          i_cfg_we,
    input  wire logic [bfmac_pkg::TAG_W-1:0]   i_cfg_wdata,
    input  wire logic [1:0]                    i_action,
    input  wire logic [bfmac_pkg::IDX_W-1:0]   i_entry_index,
    input  wire logic [bfmac_pkg::TAG_W-1:0]   i_entry_value,
    input  wire logic [7:0]                    i_msg_byte,
    input  wire logic [bfmac_pkg::TAG_W-1:0]   i_expected_tag,
    output logic                               o_done,
    output logic      [bfmac_pkg::TAG_W-1:0]   o_tag,
    output logic                               o_tag_match,
    output logic                               o_overflow
);

    localparam int AW = bfmac_pkg::ADDR_W;
    localparam int TW = bfmac_pkg::TAG_W;

    bfmac_pkg::t_state r_state, n_state;
    logic [TW-1:0] r_seed, n_seed;
    logic [TW-1:0] r_tag, n_tag;
    logic [AW-1:0] r_bit_pos, n_bit_pos;
    logic          r_ovf, n_ovf;
    logic [2:0]    r_cnt, n_cnt;
    logic [7:0]    r_byte, n_byte;
    logic [TW-1:0] r_expected, n_expected;

    logic          n_done;
    logic [TW-1:0] n_out_tag;
    logic          n_out_match;
    logic          n_out_ovf;

    logic          accept;
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [TW-1:0] ram_rdata;
    logic [TW-1:0] fin_tag;

    assign busy   = (r_state != bfmac_pkg::S_IDLE);
    assign accept = start && !busy;

    // Loads write straight from the ports in the accept cycle.
    assign ram_we = accept && (i_action == bfmac_pkg::ACT_LOAD)
                    && ({1'b0, i_entry_index} < bfmac_pkg::DEPTH_LIMIT);

    // Idle: load index, or the first bit / padding slot at the current position.
    // Byte walk: prefetch the next bit's flip word.
    always_comb begin
        if (r_state == bfmac_pkg::S_BYTE) begin
            ram_addr = r_bit_pos + AW'(r_cnt) + AW'(1);
        end else if (accept && (i_action == bfmac_pkg::ACT_LOAD)) begin
            ram_addr = i_entry_index[AW-1:0];
        end else begin
            ram_addr = r_bit_pos;
        end
    end

    bfmac_ram #(
        .WIDTH(TW),
        .DEPTH(bfmac_pkg::TABLE_DEPTH)
    ) u_flip_table (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(i_entry_value),
        .o_rdata(ram_rdata)
    );

    assign fin_tag = (r_tag ^ ram_rdata) & bfmac_pkg::TAG_MASK;

    always_comb begin
        n_state     = r_state;
        n_seed      = r_seed;
        n_tag       = r_tag;
        n_bit_pos   = r_bit_pos;
        n_ovf       = r_ovf;
        n_cnt       = r_cnt;
        n_byte      = r_byte;
        n_expected  = r_expected;
        n_done      = 1'b0;
        n_out_tag   = o_tag;
        n_out_match = o_tag_match;
        n_out_ovf   = o_overflow;

        unique case (r_state)
            bfmac_pkg::S_IDLE: begin
                if (accept) begin
                    if (i_action == bfmac_pkg::ACT_BYTE) begin
                        // Drop bytes past capacity and remember it.
                        if (r_bit_pos >= bfmac_pkg::MSG_BITS) begin
                            n_ovf = 1'b1;
                        end else begin
                            n_byte  = i_msg_byte;
                            n_cnt   = '0;
                            n_state = bfmac_pkg::S_BYTE;
                        end
                    end else if (i_action == bfmac_pkg::ACT_FINISH) begin
                        n_expected = i_expected_tag;
                        n_state    = bfmac_pkg::S_FIN;
                    end
                end
            end
            bfmac_pkg::S_BYTE: begin
                if (r_byte[7]) begin
                    n_tag = r_tag ^ ram_rdata;
                end
                n_byte = {r_byte[6:0], 1'b0};
                if (r_cnt == bfmac_pkg::BIT_LAST) begin
                    n_bit_pos = r_bit_pos + bfmac_pkg::BYTE_STEP;
                    n_state   = bfmac_pkg::S_IDLE;
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
            end
            bfmac_pkg::S_FIN: begin
                // Padding word is in; emit and restart from the seed.
                n_out_tag   = fin_tag;
                n_out_match = (fin_tag == (r_expected & bfmac_pkg::TAG_MASK));
                n_out_ovf   = r_ovf;
                n_done      = 1'b1;
                n_tag       = r_seed;
                n_bit_pos   = '0;
                n_ovf       = 1'b0;
                n_state     = bfmac_pkg::S_IDLE;
            end
            default: begin
                n_state = bfmac_pkg::S_IDLE;
            end
        endcase

        // Seed writes must arrive only while idle; the block itself does not enforce it.
        if (i_cfg_we) begin
            n_seed = i_cfg_wdata;
            if (r_bit_pos == '0) begin
                n_tag = i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= bfmac_pkg::S_IDLE;
            r_seed    <= '0;
            r_tag     <= '0;
            r_bit_pos <= '0;
            r_ovf     <= 1'b0;
            r_cnt     <= '0;
            o_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_seed    <= n_seed;
            r_tag     <= n_tag;
            r_bit_pos <= n_bit_pos;
            r_ovf     <= n_ovf;
            r_cnt     <= n_cnt;
            o_done    <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte      <= n_byte;
        r_expected  <= n_expected;
        o_tag       <= n_out_tag;
        o_tag_match <= n_out_match;
        o_overflow  <= n_out_ovf;
    end

    // A result only follows the padding read.
    a_done_after_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == bfmac_pkg::S_FIN))
        else $error("result strobe without padding read");

    // Position advances a whole byte at a time and never passes capacity.
    a_pos_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bit_pos[2:0] == 3'd0) && (r_bit_pos <= bfmac_pkg::MSG_BITS))
        else $error("bit position misaligned or past capacity");

    // A finish word goes to the padding read next.
    a_finish_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_action == bfmac_pkg::ACT_FINISH)) |=> (r_state == bfmac_pkg::S_FIN))
        else $error("finish word not followed by padding read");

    // A byte walk leaves after its eighth bit.
    a_byte_walk_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == bfmac_pkg::S_BYTE) && (r_cnt == bfmac_pkg::BIT_LAST))
        |=> (r_state == bfmac_pkg::S_IDLE))
        else $error("byte walk overran eight bits");

endmodule
`default_nettype wire

// File: tb/bfmac_tag_checker.sv
// Checker for the bit-flip MAC accumulator: predicts every tag word and compares the results.
module bfmac_tag_checker
    import bfmac_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_busy,
    input  logic             i_cfg_we,
    input  logic [TAG_W-1:0] i_cfg_wdata,
    input  logic [1:0]       i_action,
    input  logic [IDX_W-1:0] i_entry_index,
    input  logic [TAG_W-1:0] i_entry_value,
    input  logic [7:0]       i_msg_byte,
    input  logic [TAG_W-1:0] i_expected_tag,
    input  logic             i_done,
    input  logic [TAG_W-1:0] i_tag,
    input  logic             i_tag_match,
    input  logic             i_overflow,
    output int               o_fail_count,
    output int               o_pending,
    output logic [TAG_W-1:0] o_next_tag
);

    localparam int MSG_LIMIT = 8 * MAX_BYTES;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic             tag_match;
        logic             overflow;
    } tag_word_t;

    logic [TAG_W-1:0] flip_words [TABLE_DEPTH];
    logic [TAG_W-1:0] seed_reg    = '0;
    logic [TAG_W-1:0] running_tag = '0;
    int               bit_pos     = 0;
    logic             overflow_seen = 1'b0;
    tag_word_t        pending_tags [$];
    int               fail_count  = 0;

    assign o_fail_count = fail_count;
    // Tag a finish word would produce right now; lets the stimulus aim at a match.
    assign o_next_tag   = (running_tag ^ flip_words[bit_pos]) & TAG_MASK;

    task automatic report(input string what, input tag_word_t want, input tag_word_t got);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%0t: %s: expected tag %h match %b overflow %b,",
                     $realtime, what, want.tag, want.tag_match, want.overflow,
                     " got tag %h match %b overflow %b",
                     got.tag, got.tag_match, got.overflow);
        end
    endtask

    always @(posedge i_clk) begin : predict
        tag_word_t        got;
        tag_word_t        want;
        tag_word_t        fin;
        logic [TAG_W-1:0] acc;
        int               b;
        if (!i_rst_n) begin
            seed_reg      <= '0;
            running_tag   <= '0;
            bit_pos       <= 0;
            overflow_seen <= 1'b0;
            pending_tags.delete();
            o_pending     <= 0;
        end else begin
            // Retire the oldest prediction first, then queue anything accepted now.
            if (i_done) begin
                got = '{tag: i_tag, tag_match: i_tag_match, overflow: i_overflow};
                if (pending_tags.size() == 0) begin
                    report("unexpected result", '0, got);
                end else begin
                    want = pending_tags.pop_front();
                    if (got !== want) begin
                        report("result mismatch", want, got);
                    end
                end
            end
            if (i_cfg_we) begin
                seed_reg <= i_cfg_wdata;
                if (bit_pos == 0) begin
                    running_tag <= i_cfg_wdata;
                end
            end
            if (i_start && !i_busy) begin
                case (i_action)
                    ACT_LOAD: begin
                        if (i_entry_index < TABLE_DEPTH) begin
                            flip_words[i_entry_index] <= i_entry_value;
                        end
                    end
                    ACT_BYTE: begin
                        if (bit_pos >= MSG_LIMIT) begin
                            overflow_seen <= 1'b1;
                        end else begin
                            acc = running_tag;
                            for (b = 0; b < 8; b++) begin
                                if (i_msg_byte[7 - b]) begin
                                    acc = acc ^ flip_words[bit_pos + b];
                                end
                            end
                            running_tag <= acc;
                            bit_pos     <= bit_pos + 8;
                        end
                    end
                    ACT_FINISH: begin
                        fin.tag       = (running_tag ^ flip_words[bit_pos]) & TAG_MASK;
                        fin.tag_match = (fin.tag == (i_expected_tag & TAG_MASK));
                        fin.overflow  = overflow_seen;
                        pending_tags.push_back(fin);
                        running_tag   <= seed_reg;
                        bit_pos       <= 0;
                        overflow_seen <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
            o_pending <= pending_tags.size();
        end
    end

endmodule

// File: tb/bit_flip_mac_accumulator_test.sv
// Testbench top for the bit-flip MAC accumulator: clock, reset, stimulus and verdict.
module bit_flip_mac_accumulator_test;
    import bfmac_pkg::*;

    // Action code the block has no use for; it must be dropped without a result.
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    // Generous bound: every item as a slow byte with the longest sender gap, many times over.
    localparam int CYCLE_LIMIT = 300000;
    // Let a byte walk still in progress run out, with some margin to spare.
    localparam int SETTLE_CYCLES = 12;

    // How the expected tag of a finish word is chosen.
    typedef enum {
        GUESS_MATCH,
        GUESS_NEAR,
        GUESS_RANDOM
    } tag_guess_t;

    logic             i_clk          = 1'b0;
    logic             i_rst_n        = 1'b0;
    logic             start          = 1'b0;
    logic             busy;
    logic             i_cfg_we       = 1'b0;
    logic [TAG_W-1:0] i_cfg_wdata    = '0;
    logic [1:0]       i_action       = ACT_LOAD;
    logic [IDX_W-1:0] i_entry_index  = '0;
    logic [TAG_W-1:0] i_entry_value  = '0;
    logic [7:0]       i_msg_byte     = '0;
    logic [TAG_W-1:0] i_expected_tag = '0;
    logic             o_done;
    logic [TAG_W-1:0] o_tag;
    logic             o_tag_match;
    logic             o_overflow;

    int               fail_count;
    int               pending;
    logic [TAG_W-1:0] next_tag;
    int               cycle_count    = 0;
    int               sender_idle_pct = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    bit_flip_mac_accumulator u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_action       (i_action),
        .i_entry_index  (i_entry_index),
        .i_entry_value  (i_entry_value),
        .i_msg_byte     (i_msg_byte),
        .i_expected_tag (i_expected_tag),
        .o_done         (o_done),
        .o_tag          (o_tag),
        .o_tag_match    (o_tag_match),
        .o_overflow     (o_overflow)
    );

    bfmac_tag_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_action       (i_action),
        .i_entry_index  (i_entry_index),
        .i_entry_value  (i_entry_value),
        .i_msg_byte     (i_msg_byte),
        .i_expected_tag (i_expected_tag),
        .i_done         (o_done),
        .i_tag          (o_tag),
        .i_tag_match    (o_tag_match),
        .i_overflow     (o_overflow),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_next_tag     (next_tag)
    );

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [TAG_W-1:0] random_word();
        return {$urandom, $urandom};
    endfunction

    // Flip words: mostly random, with the all-ones and all-zeros extremes mixed in.
    function automatic logic [TAG_W-1:0] flip_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
            return '1;
        end else if (roll < 15) begin
            return '0;
        end
        return random_word();
    endfunction

    // Drop start for a random stretch now and then, so gaps land on every busy cycle.
    task automatic pause_sender();
        if ($urandom_range(0, 99) < sender_idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
    endtask

    // Present one word and hold it until the block takes it. Start stays high on return
    // so a following word goes out back to back.
    task automatic issue(input logic [1:0] act, input logic [IDX_W-1:0] idx,
                         input logic [TAG_W-1:0] val, input logic [7:0] msg,
                         input logic [TAG_W-1:0] exp_tag);
        start          <= 1'b1;
        i_action       <= act;
        i_entry_index  <= idx;
        i_entry_value  <= val;
        i_msg_byte     <= msg;
        i_expected_tag <= exp_tag;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic load_entry(input int idx, input logic [TAG_W-1:0] val);
        issue(ACT_LOAD, IDX_W'(idx), val, 8'($urandom), random_word());
    endtask

    task automatic send_byte(input logic [7:0] msg);
        issue(ACT_BYTE, IDX_W'($urandom_range(0, 1023)), random_word(), msg, random_word());
    endtask

    // Words the block must drop: the spare action code or a load past the table end.
    task automatic send_noise();
        if ($urandom_range(0, 1) == 0) begin
            issue(ACT_UNUSED, IDX_W'($urandom_range(0, 1023)), random_word(), 8'($urandom),
                  random_word());
        end else begin
            load_entry($urandom_range(TABLE_DEPTH, 1023), random_word());
        end
    endtask

    // Close the message. For a match or a near miss, idle first so the checker's
    // running tag already covers every word taken so far.
    task automatic finish_message(input tag_guess_t guess);
        logic [TAG_W-1:0] exp_tag;
        exp_tag = random_word();
        if (guess != GUESS_RANDOM) begin
            start <= 1'b0;
            @(posedge i_clk);
            exp_tag = next_tag;
            if (guess == GUESS_NEAR) begin
                exp_tag = exp_tag ^ (64'd1 << $urandom_range(0, TAG_W - 1));
            end
        end
        issue(ACT_FINISH, IDX_W'($urandom_range(0, 1023)), random_word(), 8'($urandom), exp_tag);
    endtask

    // Hold off until every result is back and the block has gone quiet, then write the seed.
    task automatic settle_and_seed(input logic [TAG_W-1:0] seed);
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= seed;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Random traffic: mostly whole messages with random content, some reloads mid-message,
    // a little noise, and now and then a message that runs past the table capacity.
    task automatic run_phase(input int budget);
        int sent;
        int nbytes;
        int roll;
        bit first;
        sent  = 0;
        first = 1'b1;
        while (sent < budget) begin
            if (first) begin
                nbytes = $urandom_range(65, 67);
            end else if ($urandom_range(0, 99) < 3) begin
                nbytes = $urandom_range(60, 68);
            end else begin
                nbytes = $urandom_range(0, 6);
            end
            first = 1'b0;
            repeat (nbytes) begin
                roll = $urandom_range(0, 99);
                if (roll < 10) begin
                    pause_sender();
                    load_entry($urandom_range(0, TABLE_DEPTH - 1), flip_value());
                    sent++;
                end else if (roll < 14) begin
                    pause_sender();
                    send_noise();
                end
                pause_sender();
                send_byte(8'($urandom));
                sent++;
            end
            roll = $urandom_range(0, 99);
            pause_sender();
            if (roll < 40) begin
                finish_message(GUESS_MATCH);
            end else if (roll < 60) begin
                finish_message(GUESS_NEAR);
            end else begin
                finish_message(GUESS_RANDOM);
            end
            sent++;
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        settle_and_seed(random_word());

        // Fill every table entry once so no read ever hits an unwritten word.
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            load_entry(i, flip_value());
        end

        // Directed: index and value extremes, dropped words, empty message.
        load_entry(TABLE_DEPTH - 1, '1);
        load_entry(0, '0);
        load_entry(1023, random_word());
        load_entry(TABLE_DEPTH, random_word());
        issue(ACT_UNUSED, '1, '1, '1, '1);
        finish_message(GUESS_MATCH);

        // Byte extremes and single edge bits.
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h80);
        send_byte(8'h01);
        finish_message(GUESS_RANDOM);

        // Seed change mid-message: this message keeps the old seed, the next one takes it.
        send_byte(8'h5A);
        settle_and_seed('1);
        finish_message(GUESS_MATCH);
        finish_message(GUESS_MATCH);

        // Seed change between messages, then a reload of a position not yet read.
        settle_and_seed('0);
        send_byte(8'hC3);
        load_entry(9, random_word());
        send_byte(8'hFF);
        finish_message(GUESS_NEAR);

        // Light sender gaps.
        sender_idle_pct = 8;
        settle_and_seed(random_word());
        run_phase(107);

        // Heavy sender gaps.
        sender_idle_pct = 47;
        settle_and_seed('1);
        run_phase(107);

        // Back to back, no gaps at all.
        sender_idle_pct = 0;
        settle_and_seed(random_word());
        run_phase(106);

        // Drain: wait for every result, then give the block time to show a stray one.
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
